### hw/rtl/ypcu_pkg.sv
package ypcu_pkg;

    typedef struct packed {
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic [5:0]         keys_held;
        logic               toggle_pressed;
        logic [15:0]        delta_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic               game_mode;
    } t_out_item;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_SENS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 2'd2;

    localparam logic [15:0] SENS_RST = 16'd6554;
    localparam logic [15:0] GAIN_RST = 16'd3840;
    localparam logic [14:0] PLIM_RST = 15'd22784;

    localparam logic [2:0] KEY_FORWARD = 3'd0;
    localparam logic [2:0] KEY_BACK    = 3'd1;
    localparam logic [2:0] KEY_LEFT    = 3'd2;
    localparam logic [2:0] KEY_RIGHT   = 3'd3;
    localparam logic [2:0] KEY_DOWN    = 3'd4;
    localparam logic [2:0] KEY_UP      = 3'd5;

    localparam int MUL_W      = 33;
    localparam int SC_FRAC    = 30;
    localparam int SPEED_FRAC = 24;

    localparam int CRD_FRAC  = 24;
    localparam int CRD_STEPS = 24;
    localparam int CRD_ZW    = 34;
    localparam int CRD_XW    = 33;
    localparam logic [4:0] CRD_LAST = 5'd23;

    localparam logic signed [CRD_XW-1:0] CRD_X0      = 33'sd652032874;
    localparam logic signed [CRD_ZW-1:0] CRD_FULL    = 34'sd6039797760;
    localparam logic signed [CRD_ZW-1:0] CRD_HALF    = 34'sd3019898880;
    localparam logic signed [CRD_ZW-1:0] CRD_QUARTER = 34'sd1509949440;

    localparam logic signed [CRD_ZW-1:0] CRD_ATAN [CRD_STEPS] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115
    };

endpackage

### hw/rtl/yaw_pitch_camera_update.sv
// Channel  | Valid        | Ready        | Payload
// input    | i_in_valid   | o_in_ready   | i_in_item  (ypcu_pkg::t_in_item)
// result   | o_out_valid  | i_out_ready  | o_out_item (ypcu_pkg::t_out_item)
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// In game mode an item goes through the two 24-step CORDIC passes and the shared
// multiplier, with a move for each held key; in UI mode it goes straight to S_DONE.
// One item is in work at a time; o_in_ready is high only while idle.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous and active low and restores the camera state.
module yaw_pitch_camera_update #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int VEC_FRAC_BITS   = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ypcu_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ypcu_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ypcu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [15:0]                          i_cfg_data
);

    localparam int AW     = ANGLE_FRAC_BITS + 17;
    localparam int VW     = VEC_FRAC_BITS + 2;
    localparam int MW     = ypcu_pkg::MUL_W;
    localparam int PW     = 2 * MW;
    localparam int XW     = ypcu_pkg::CRD_XW;
    localparam int ZW     = ypcu_pkg::CRD_ZW;
    localparam int SH_UP  = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
    localparam int SH_DN  = (ANGLE_FRAC_BITS >= 16) ? 0 : 16 - ANGLE_FRAC_BITS;
    localparam int RND_DN = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;
    localparam int DW     = 34 + SH_UP;
    localparam int CRD_UP = ypcu_pkg::CRD_FRAC - ANGLE_FRAC_BITS;
    localparam int GW     = AW + CRD_UP;
    localparam int SH1    = ypcu_pkg::SC_FRAC - VEC_FRAC_BITS;
    localparam int SH2    = 2 * ypcu_pkg::SC_FRAC - VEC_FRAC_BITS;
    localparam int SHM    = VEC_FRAC_BITS + ypcu_pkg::SPEED_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [VW-1:0] VONE   = VW'(1 << VEC_FRAC_BITS);
    localparam logic signed [PW-1:0] VONE_P = PW'(1 << VEC_FRAC_BITS);
    localparam logic [AW-1:0]        FULL_A = AW'(360) << ANGLE_FRAC_BITS;
    localparam logic signed [XW-1:0] RND1   = XW'(1 << (SH1 - 1));
    localparam logic signed [PW-1:0] RND2   = PW'(1) << (SH2 - 1);
    localparam logic signed [PW-1:0] RNDM   = PW'(1) << (SHM - 1);
    localparam logic signed [31:0]   POS_Z0 = 32'(1 << (ANGLE_FRAC_BITS - 1));
    localparam logic signed [PW-1:0] POS_MAX = PW'(2147483647);
    localparam logic signed [PW-1:0] POS_MIN = -POS_MAX - PW'(1);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_YAW_MUL  = 16'b0000_0000_0000_0010,
        S_YAW_ADD  = 16'b0000_0000_0000_0100,
        S_YAW_MOD  = 16'b0000_0000_0000_1000,
        S_YAW_FIX  = 16'b0000_0000_0001_0000,
        S_PIT_MUL  = 16'b0000_0000_0010_0000,
        S_PIT_ADD  = 16'b0000_0000_0100_0000,
        S_CRD_PREP = 16'b0000_0000_1000_0000,
        S_CRD_ITER = 16'b0000_0001_0000_0000,
        S_VEC_MUL  = 16'b0000_0010_0000_0000,
        S_VEC_RND  = 16'b0000_0100_0000_0000,
        S_VEC_SET  = 16'b0000_1000_0000_0000,
        S_SPD_MUL  = 16'b0001_0000_0000_0000,
        S_MV_MUL   = 16'b0010_0000_0000_0000,
        S_MV_ADD   = 16'b0100_0000_0000_0000,
        S_DONE     = 16'b1000_0000_0000_0000
    } t_state;

    function automatic logic signed [VW-1:0] unit1(input logic signed [XW-1:0] q);
        logic signed [XW-1:0] t;
        t = (q + RND1) >>> SH1;
        if (t > VONE) begin
            return VONE;
        end else if (t < -VONE) begin
            return -VONE;
        end
        return VW'(t);
    endfunction

    function automatic logic signed [VW-1:0] sgm(input logic signed [VW-1:0] v,
                                                 input logic pos, input logic neg);
        if (pos) begin
            return v;
        end else if (neg) begin
            return -v;
        end
        return '0;
    endfunction

    t_state                    r_state, n_state;
    logic [4:0]                r_cnt, n_cnt;
    logic [2:0]                r_key, n_key;
    logic [1:0]                r_comp, n_comp;
    logic                      r_sel, n_sel;
    logic                      r_neg, n_neg;
    logic                      r_vneg, n_vneg;
    logic [15:0]               r_sens, n_sens;
    logic [15:0]               r_gain, n_gain;
    logic [14:0]               r_plim, n_plim;
    ypcu_pkg::t_in_item        r_in, n_in;
    logic signed [AW-1:0]      r_yaw, n_yaw;
    logic signed [AW-1:0]      r_pitch, n_pitch;
    logic [AW-1:0]             r_mag, n_mag;
    logic signed [PW-1:0]      r_prod, n_prod;
    logic [31:0]               r_speed, n_speed;
    logic signed [XW-1:0]      r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0]      r_z, n_z;
    logic signed [XW-1:0]      r_cy, n_cy, r_sy, n_sy, r_cp, n_cp, r_sp, n_sp;
    logic signed [VW-1:0]      r_u [4];
    logic signed [VW-1:0]      n_u [4];
    logic signed [31:0]        r_pos [3];
    logic signed [31:0]        n_pos [3];
    logic signed [VW-1:0]      r_front [3];
    logic signed [VW-1:0]      n_front [3];
    logic signed [VW-1:0]      r_right [2];
    logic signed [VW-1:0]      n_right [2];
    logic signed [VW-1:0]      r_up [3];
    logic signed [VW-1:0]      n_up [3];
    logic                      r_mode, n_mode;
    ypcu_pkg::t_out_item       r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic signed [MW-1:0]      mul_a, mul_b;
    logic signed [PW-1:0]      mul_p;
    logic signed [DW-1:0]      ang_w;
    logic signed [AW-1:0]      ang_d, yaw_v, pit_t, pit_c, lim, ang_sel;
    logic [AW-1:0]             yaw_abs, full_sh;
    logic signed [GW-1:0]      ang_g;
    logic signed [ZW-1:0]      z0, z1, z2, crd_at, crd_nz;
    logic                      z_neg;
    logic signed [XW-1:0]      crd_dx, crd_dy, crd_nx, crd_ny;
    logic signed [PW-1:0]      u2_w, mv_d, mv_sum, mv_clip;
    logic signed [VW-1:0]      u2_c;
    logic signed [VW-1:0]      mv_vec [3];
    logic                      mv_neg, cp_pos, cp_neg;

    assign mul_p = mul_a * mul_b;

    assign ang_w = (($signed({{(DW-33){r_prod[32]}}, r_prod[32:0]}) <<< SH_UP)
                   + DW'(RND_DN)) >>> SH_DN;
    assign ang_d   = AW'(ang_w);
    assign yaw_v   = r_yaw - ang_d;
    assign yaw_abs = yaw_v[AW-1] ? AW'(-yaw_v) : AW'(yaw_v);
    assign full_sh = FULL_A << r_cnt[2:0];

    assign lim   = $signed(AW'(r_plim) << (ANGLE_FRAC_BITS - 8));
    assign pit_t = r_pitch + ang_d;
    assign pit_c = (pit_t > lim) ? lim : ((pit_t < -lim) ? -lim : pit_t);

    assign ang_sel = r_sel ? r_pitch : r_yaw;
    assign ang_g   = GW'(ang_sel) <<< CRD_UP;
    assign z0      = ZW'(ang_g);
    assign z1      = (z0 < -ypcu_pkg::CRD_HALF) ? z0 + ypcu_pkg::CRD_FULL :
                     ((z0 > ypcu_pkg::CRD_HALF) ? z0 - ypcu_pkg::CRD_FULL : z0);
    assign z_neg   = (z1 > ypcu_pkg::CRD_QUARTER) || (z1 < -ypcu_pkg::CRD_QUARTER);
    assign z2      = (z1 > ypcu_pkg::CRD_QUARTER) ? z1 - ypcu_pkg::CRD_HALF :
                     ((z1 < -ypcu_pkg::CRD_QUARTER) ? z1 + ypcu_pkg::CRD_HALF : z1);

    assign crd_dx = r_y >>> r_cnt;
    assign crd_dy = r_x >>> r_cnt;
    assign crd_at = ypcu_pkg::CRD_ATAN[r_cnt];
    assign crd_nx = r_z[ZW-1] ? r_x + crd_dx : r_x - crd_dx;
    assign crd_ny = r_z[ZW-1] ? r_y - crd_dy : r_y + crd_dy;
    assign crd_nz = r_z[ZW-1] ? r_z + crd_at : r_z - crd_at;

    assign u2_w = (r_prod + RND2) >>> SH2;
    assign u2_c = (u2_w > VONE_P) ? VONE : ((u2_w < -VONE_P) ? -VONE : VW'(u2_w));

    assign cp_neg = r_cp[XW-1];
    assign cp_pos = !r_cp[XW-1] && (r_cp != '0);

    always_comb begin
        case (r_key)
            ypcu_pkg::KEY_FORWARD, ypcu_pkg::KEY_BACK: begin
                mv_vec[0] = -r_right[1];
                mv_vec[1] = r_right[0];
                mv_vec[2] = '0;
            end
            ypcu_pkg::KEY_LEFT, ypcu_pkg::KEY_RIGHT: begin
                mv_vec[0] = r_right[0];
                mv_vec[1] = r_right[1];
                mv_vec[2] = '0;
            end
            default: begin
                mv_vec[0] = r_up[0];
                mv_vec[1] = r_up[1];
                mv_vec[2] = r_up[2];
            end
        endcase
    end

    assign mv_neg  = (r_key == ypcu_pkg::KEY_BACK) || (r_key == ypcu_pkg::KEY_LEFT)
                     || (r_key == ypcu_pkg::KEY_DOWN);
    assign mv_d    = (r_prod + RNDM) >>> SHM;
    assign mv_sum  = mv_neg ? PW'(r_pos[r_comp]) - mv_d : PW'(r_pos[r_comp]) + mv_d;
    assign mv_clip = (mv_sum > POS_MAX) ? POS_MAX : ((mv_sum < POS_MIN) ? POS_MIN : mv_sum);

    always_comb begin
        case (r_state)
            S_YAW_MUL: begin
                mul_a = MW'(r_in.mouse_dx);
                mul_b = $signed({{(MW-16){1'b0}}, r_sens});
            end
            S_PIT_MUL: begin
                mul_a = -MW'(r_in.mouse_dy);
                mul_b = $signed({{(MW-16){1'b0}}, r_sens});
            end
            S_VEC_MUL: begin
                mul_a = r_cnt[0] ? MW'(r_cy) : MW'(r_sy);
                mul_b = r_cnt[1] ? MW'(r_sp) : MW'(r_cp);
            end
            S_SPD_MUL: begin
                mul_a = $signed({{(MW-16){1'b0}}, r_gain});
                mul_b = $signed({{(MW-16){1'b0}}, r_in.delta_time});
            end
            S_MV_MUL: begin
                mul_a = MW'(mv_vec[r_comp]);
                mul_b = $signed({1'b0, r_speed});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_comp      = r_comp;
        n_sel       = r_sel;
        n_neg       = r_neg;
        n_vneg      = r_vneg;
        n_sens      = r_sens;
        n_gain      = r_gain;
        n_plim      = r_plim;
        n_in        = r_in;
        n_yaw       = r_yaw;
        n_pitch     = r_pitch;
        n_mag       = r_mag;
        n_prod      = r_prod;
        n_speed     = r_speed;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_cy        = r_cy;
        n_sy        = r_sy;
        n_cp        = r_cp;
        n_sp        = r_sp;
        n_u         = r_u;
        n_pos       = r_pos;
        n_front     = r_front;
        n_right     = r_right;
        n_up        = r_up;
        n_mode      = r_mode;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                ypcu_pkg::CFG_MOUSE_SENS:  n_sens = i_cfg_data;
                ypcu_pkg::CFG_MOVE_GAIN:   n_gain = i_cfg_data;
                ypcu_pkg::CFG_PITCH_LIMIT: n_plim = i_cfg_data[14:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_item;
                    n_state = r_mode ? S_YAW_MUL : S_DONE;
                end
            end
            S_YAW_MUL: begin
                n_prod  = mul_p;
                n_state = S_YAW_ADD;
            end
            S_YAW_ADD: begin
                n_vneg  = yaw_v[AW-1];
                n_mag   = yaw_abs;
                n_cnt   = 5'd7;
                n_state = S_YAW_MOD;
            end
            S_YAW_MOD: begin
                if (r_mag >= full_sh) begin
                    n_mag = r_mag - full_sh;
                end
                if (r_cnt[2:0] == 3'd0) begin
                    n_state = S_YAW_FIX;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_YAW_FIX: begin
                n_yaw   = (r_vneg && (r_mag != '0)) ? $signed(FULL_A - r_mag) : $signed(r_mag);
                n_state = S_PIT_MUL;
            end
            S_PIT_MUL: begin
                n_prod  = mul_p;
                n_state = S_PIT_ADD;
            end
            S_PIT_ADD: begin
                n_pitch = pit_c;
                n_sel   = 1'b0;
                n_state = S_CRD_PREP;
            end
            S_CRD_PREP: begin
                n_x     = ypcu_pkg::CRD_X0;
                n_y     = '0;
                n_z     = z2;
                n_neg   = z_neg;
                n_cnt   = '0;
                n_state = S_CRD_ITER;
            end
            S_CRD_ITER: begin
                n_x = crd_nx;
                n_y = crd_ny;
                n_z = crd_nz;
                if (r_cnt == ypcu_pkg::CRD_LAST) begin
                    n_cnt = '0;
                    if (r_sel) begin
                        n_cp    = r_neg ? -crd_nx : crd_nx;
                        n_sp    = r_neg ? -crd_ny : crd_ny;
                        n_state = S_VEC_MUL;
                    end else begin
                        n_cy    = r_neg ? -crd_nx : crd_nx;
                        n_sy    = r_neg ? -crd_ny : crd_ny;
                        n_sel   = 1'b1;
                        n_state = S_CRD_PREP;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_VEC_MUL: begin
                n_prod  = mul_p;
                n_state = S_VEC_RND;
            end
            S_VEC_RND: begin
                n_u[r_cnt[1:0]] = u2_c;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_VEC_SET;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_VEC_MUL;
                end
            end
            S_VEC_SET: begin
                n_front[0] = r_u[0];
                n_front[1] = -r_u[1];
                n_front[2] = unit1(r_sp);
                n_right[0] = sgm(-unit1(r_cy), cp_pos, cp_neg);
                n_right[1] = sgm(-unit1(r_sy), cp_pos, cp_neg);
                n_up[0]    = sgm(-r_u[2], cp_pos, cp_neg);
                n_up[1]    = sgm(r_u[3], cp_pos, cp_neg);
                n_up[2]    = unit1(cp_neg ? -r_cp : r_cp);
                n_state    = S_SPD_MUL;
            end
            S_SPD_MUL: begin
                n_speed = mul_p[31:0];
                n_key   = ypcu_pkg::KEY_FORWARD;
                n_comp  = '0;
                n_state = S_MV_MUL;
            end
            S_MV_MUL: begin
                if (r_in.keys_held[r_key]) begin
                    n_prod  = mul_p;
                    n_state = S_MV_ADD;
                end else if (r_key == ypcu_pkg::KEY_UP) begin
                    n_state = S_DONE;
                end else begin
                    n_key = r_key + 3'd1;
                end
            end
            S_MV_ADD: begin
                n_pos[r_comp] = 32'(mv_clip);
                n_state       = S_MV_MUL;
                if (r_comp == 2'd2) begin
                    n_comp = '0;
                    if (r_key == ypcu_pkg::KEY_UP) begin
                        n_state = S_DONE;
                    end else begin
                        n_key = r_key + 3'd1;
                    end
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_mode            = r_mode ^ r_in.toggle_pressed;
                    n_out.pos_x       = r_pos[0];
                    n_out.pos_y       = r_pos[1];
                    n_out.pos_z       = r_pos[2];
                    n_out.front_x     = 16'(r_front[0]);
                    n_out.front_y     = 16'(r_front[1]);
                    n_out.front_z     = 16'(r_front[2]);
                    n_out.right_x     = 16'(r_right[0]);
                    n_out.right_y     = 16'(r_right[1]);
                    n_out.up_x        = 16'(r_up[0]);
                    n_out.up_y        = 16'(r_up[1]);
                    n_out.up_z        = 16'(r_up[2]);
                    n_out.game_mode   = r_mode ^ r_in.toggle_pressed;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b1;
            r_sens      <= ypcu_pkg::SENS_RST;
            r_gain      <= ypcu_pkg::GAIN_RST;
            r_plim      <= ypcu_pkg::PLIM_RST;
            r_yaw       <= '0;
            r_pitch     <= '0;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_pos[2]    <= POS_Z0;
            r_front[0]  <= '0;
            r_front[1]  <= -VONE;
            r_front[2]  <= '0;
            r_right[0]  <= VONE;
            r_right[1]  <= '0;
            r_up[0]     <= '0;
            r_up[1]     <= '0;
            r_up[2]     <= VONE;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_sens      <= n_sens;
            r_gain      <= n_gain;
            r_plim      <= n_plim;
            r_yaw       <= n_yaw;
            r_pitch     <= n_pitch;
            r_pos       <= n_pos;
            r_front     <= n_front;
            r_right     <= n_right;
            r_up        <= n_up;
        end
        r_cnt   <= n_cnt;
        r_key   <= n_key;
        r_comp  <= n_comp;
        r_sel   <= n_sel;
        r_neg   <= n_neg;
        r_vneg  <= n_vneg;
        r_in    <= n_in;
        r_mag   <= n_mag;
        r_prod  <= n_prod;
        r_speed <= n_speed;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_cy    <= n_cy;
        r_sy    <= n_sy;
        r_cp    <= n_cp;
        r_sp    <= n_sp;
        r_u     <= n_u;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_yaw[AW-1] && ($unsigned(r_yaw) < FULL_A))
        else $error("Yaw angle has left the range of one turn.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Block is ready again straight after taking an item.");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("Result appeared outside the final state.");

    a_cordic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRD_ITER) |-> (r_cnt <= ypcu_pkg::CRD_LAST))
        else $error("CORDIC step count has run past the last step.");

endmodule

### sim/yaw_pitch_camera_update_test.sv
module yaw_pitch_camera_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint VONE = 64'sd16384;
    localparam longint ANG_FULL = 64'sd360 <<< 16;
    localparam longint CRD_FULL_L = 64'sd360 <<< 24;
    localparam longint CRD_HALF_L = 64'sd180 <<< 24;
    localparam longint CRD_QUARTER_L = 64'sd90 <<< 24;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam logic [ypcu_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ypcu_pkg::t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ypcu_pkg::t_out_item out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ypcu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    longint sens_reg, gain_reg, plim_reg;
    longint yaw_acc, pitch_acc;
    longint cam_pos [3];
    longint cam_front [3];
    longint cam_right [3];
    longint cam_up [3];
    bit game_flag;

    ypcu_pkg::t_out_item pending_views [$];

    yaw_pitch_camera_update u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint shift_down(longint v, int s);
        if (s <= 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void cordic_sincos(longint ang, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = ang % CRD_FULL_L;
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        if (z < 0) z += CRD_FULL_L;
        if (z > CRD_HALF_L) z -= CRD_FULL_L;
        if (z > CRD_QUARTER_L) begin
            z -= CRD_HALF_L;
            flip = 1'b1;
        end else if (z < -CRD_QUARTER_L) begin
            z += CRD_HALF_L;
            flip = 1'b1;
        end
        for (int i = 0; i < ypcu_pkg::CRD_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ypcu_pkg::CRD_ATAN[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ypcu_pkg::CRD_ATAN[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint scale_one(longint q30);
        return clip(shift_down(q30, 16), -VONE, VONE);
    endfunction

    function automatic longint scale_prod(longint a, longint b);
        return clip(shift_down(a * b, 46), -VONE, VONE);
    endfunction

    function automatic void shift_camera(longint v [3], longint dir, longint speed);
        longint d;
        for (int k = 0; k < 3; k++) begin
            d = shift_down(v[k] * speed, 22);
            cam_pos[k] = clip(cam_pos[k] + dir * d, POS_MIN, POS_MAX);
        end
    endfunction

    function automatic void reset_camera();
        sens_reg = ypcu_pkg::SENS_RST;
        gain_reg = ypcu_pkg::GAIN_RST;
        plim_reg = ypcu_pkg::PLIM_RST;
        yaw_acc = 0;
        pitch_acc = 0;
        cam_pos = '{0, 0, 32768};
        cam_front = '{0, -VONE, 0};
        cam_right = '{VONE, 0, 0};
        cam_up = '{0, 0, VONE};
        game_flag = 1'b1;
    endfunction

    function automatic ypcu_pkg::t_out_item advance_camera(ypcu_pkg::t_in_item it);
        longint dx, dy, speed, lim, cy, sy, cp, sp, sg;
        longint fwd [3];
        ypcu_pkg::t_out_item r;
        if (game_flag) begin
            dx = longint'(it.mouse_dx);
            dy = longint'(it.mouse_dy);
            speed = gain_reg * longint'(it.delta_time);
            lim = plim_reg <<< 8;
            yaw_acc = (yaw_acc - dx * sens_reg) % ANG_FULL;
            if (yaw_acc < 0) yaw_acc += ANG_FULL;
            pitch_acc = clip(pitch_acc - dy * sens_reg, -lim, lim);
            cordic_sincos(yaw_acc <<< 8, cy, sy);
            cordic_sincos(pitch_acc <<< 8, cp, sp);
            sg = cp > 0 ? 1 : (cp < 0 ? -1 : 0);
            cam_front[0] = scale_prod(sy, cp);
            cam_front[1] = -scale_prod(cy, cp);
            cam_front[2] = scale_one(sp);
            cam_right[0] = -sg * scale_one(cy);
            cam_right[1] = -sg * scale_one(sy);
            cam_right[2] = 0;
            cam_up[0] = -sg * scale_prod(sy, sp);
            cam_up[1] = sg * scale_prod(cy, sp);
            cam_up[2] = scale_one(cp < 0 ? -cp : cp);
            fwd[0] = sg * scale_one(sy);
            fwd[1] = -sg * scale_one(cy);
            fwd[2] = 0;
            if (it.keys_held[ypcu_pkg::KEY_FORWARD]) shift_camera(fwd, 1, speed);
            if (it.keys_held[ypcu_pkg::KEY_BACK]) shift_camera(fwd, -1, speed);
            if (it.keys_held[ypcu_pkg::KEY_LEFT]) shift_camera(cam_right, -1, speed);
            if (it.keys_held[ypcu_pkg::KEY_RIGHT]) shift_camera(cam_right, 1, speed);
            if (it.keys_held[ypcu_pkg::KEY_DOWN]) shift_camera(cam_up, -1, speed);
            if (it.keys_held[ypcu_pkg::KEY_UP]) shift_camera(cam_up, 1, speed);
        end
        if (it.toggle_pressed) game_flag = !game_flag;
        r.pos_x = cam_pos[0][31:0];
        r.pos_y = cam_pos[1][31:0];
        r.pos_z = cam_pos[2][31:0];
        r.front_x = cam_front[0][15:0];
        r.front_y = cam_front[1][15:0];
        r.front_z = cam_front[2][15:0];
        r.right_x = cam_right[0][15:0];
        r.right_y = cam_right[1][15:0];
        r.up_x = cam_up[0][15:0];
        r.up_y = cam_up[1][15:0];
        r.up_z = cam_up[2][15:0];
        r.game_mode = game_flag;
        return r;
    endfunction

    task automatic send_tick(ypcu_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_views.push_back(advance_camera(it));
        items_sent++;
    endtask

    task automatic write_reg(logic [ypcu_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ypcu_pkg::CFG_MOUSE_SENS: sens_reg = val;
            ypcu_pkg::CFG_MOVE_GAIN: gain_reg = val;
            ypcu_pkg::CFG_PITCH_LIMIT: plim_reg = val[14:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic ypcu_pkg::t_in_item rand_tick(int key_bias);
        ypcu_pkg::t_in_item it;
        it.mouse_dx = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(400) - 200);
        it.mouse_dy = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(400) - 200);
        it.keys_held = $urandom_range(99) < key_bias ? 6'($urandom) : 6'd0;
        it.toggle_pressed = $urandom_range(19) == 0;
        it.delta_time = 16'($urandom);
        return it;
    endfunction

    function automatic ypcu_pkg::t_in_item make_tick(int dx, int dy, int keys, bit tog, int dt);
        ypcu_pkg::t_in_item it;
        it.mouse_dx = 16'(dx);
        it.mouse_dy = 16'(dy);
        it.keys_held = 6'(keys);
        it.toggle_pressed = tog;
        it.delta_time = 16'(dt);
        return it;
    endfunction

    task automatic test_directed();
        send_tick(make_tick(0, 0, 0, 0, 0));
        send_tick(make_tick(-32768, 32767, 63, 0, 65535));
        send_tick(make_tick(32767, -32768, 1, 0, 65535));
        for (int k = 0; k < 6; k++) send_tick(make_tick(100, -50, 1 << k, 0, 40000));
        send_tick(make_tick(0, -32768, 2, 0, 1000));
        send_tick(make_tick(0, 32767, 4, 0, 1000));
        send_tick(make_tick(5, 5, 63, 1, 65535));
        send_tick(make_tick(-32768, -32768, 63, 0, 65535));
        send_tick(make_tick(0, 0, 0, 1, 0));
        drain();
        write_reg(ypcu_pkg::CFG_PITCH_LIMIT, 16'd23040);
        write_reg(ypcu_pkg::CFG_MOVE_GAIN, 16'hFFFF);
        write_reg(ypcu_pkg::CFG_MOUSE_SENS, 16'hFFFF);
        write_reg(CFG_SPARE, 16'h1234);
        send_tick(make_tick(0, -32768, 48, 0, 65535));
        send_tick(make_tick(0, 32767, 15, 0, 65535));
        send_tick(make_tick(12345, -20000, 63, 0, 65535));
        drain();
        write_reg(ypcu_pkg::CFG_MOUSE_SENS, 16'd0);
        write_reg(ypcu_pkg::CFG_PITCH_LIMIT, 16'd0);
        write_reg(ypcu_pkg::CFG_MOVE_GAIN, 16'd0);
        send_tick(make_tick(-32768, 32767, 63, 0, 65535));
        send_tick(make_tick(1, 1, 0, 0, 1));
        drain();
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 180 == 179) begin
                drain();
                write_reg(ypcu_pkg::CFG_MOUSE_SENS,
                          $urandom_range(3) == 0 ? 16'($urandom) : 16'd6554);
                write_reg(ypcu_pkg::CFG_MOVE_GAIN, 16'($urandom));
                write_reg(ypcu_pkg::CFG_PITCH_LIMIT, 16'($urandom_range(23040)));
            end
            send_tick(rand_tick(80));
        end
        drain();
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            out_ready <= $urandom_range(99) >= recv_stall_pct;
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_views.size() == 0) begin
                    $error("result with nothing expected");
                    fail_count++;
                end else begin
                    ypcu_pkg::t_out_item e;
                    e = pending_views.pop_front();
                    if (out_item.pos_x !== e.pos_x) begin
                        $error("pos_x exp %0d got %0d", e.pos_x, out_item.pos_x); fail_count++;
                    end
                    if (out_item.pos_y !== e.pos_y) begin
                        $error("pos_y exp %0d got %0d", e.pos_y, out_item.pos_y); fail_count++;
                    end
                    if (out_item.pos_z !== e.pos_z) begin
                        $error("pos_z exp %0d got %0d", e.pos_z, out_item.pos_z); fail_count++;
                    end
                    if (out_item.front_x !== e.front_x) begin
                        $error("front_x exp %0d got %0d", e.front_x, out_item.front_x); fail_count++;
                    end
                    if (out_item.front_y !== e.front_y) begin
                        $error("front_y exp %0d got %0d", e.front_y, out_item.front_y); fail_count++;
                    end
                    if (out_item.front_z !== e.front_z) begin
                        $error("front_z exp %0d got %0d", e.front_z, out_item.front_z); fail_count++;
                    end
                    if (out_item.right_x !== e.right_x) begin
                        $error("right_x exp %0d got %0d", e.right_x, out_item.right_x); fail_count++;
                    end
                    if (out_item.right_y !== e.right_y) begin
                        $error("right_y exp %0d got %0d", e.right_y, out_item.right_y); fail_count++;
                    end
                    if (out_item.up_x !== e.up_x) begin
                        $error("up_x exp %0d got %0d", e.up_x, out_item.up_x); fail_count++;
                    end
                    if (out_item.up_y !== e.up_y) begin
                        $error("up_y exp %0d got %0d", e.up_y, out_item.up_y); fail_count++;
                    end
                    if (out_item.up_z !== e.up_z) begin
                        $error("up_z exp %0d got %0d", e.up_z, out_item.up_z); fail_count++;
                    end
                    if (out_item.game_mode !== e.game_mode) begin
                        $error("game_mode exp %0d got %0d", e.game_mode, out_item.game_mode);
                        fail_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        reset_camera();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 33;
        recv_stall_pct = 79;
        test_random(500);
        send_idle_pct = 79;
        recv_stall_pct = 33;
        test_random(500);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(600);
        $display("Sent %0d camera ticks and checked %0d results over three idling phases.",
                 items_sent, results_seen);
        $display("Register settings included the zero and full-scale extremes.");
        if (fail_count == 0 && pending_views.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
